// ===== rtl/core/crcwd_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the CRC-checked word deframer.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package crcwd_pkg;

  localparam int MAX_WORDS_DEF = 32;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int INDEX_W = 5;
  localparam int WPR_W   = 6;

  localparam logic [WPR_W-1:0]  WPR_RESET = 6'd1;
  localparam logic [BYTE_W-1:0] CRC_INIT  = 8'hFF;
  localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_TOP   = 8'h80;

  typedef enum logic [2:0] {
    PH_MSB = 3'b001,
    PH_LSB = 3'b010,
    PH_CRC = 3'b100
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } byte_stage_t;

  // CRC-8, MSB first, no reflection, no final XOR
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc_in ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if ((c & CRC_TOP) != '0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/crcwd_if.sv =====
// Valid/ready channel interfaces: received bytes in, checked words out.
// Depends on crcwd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface crcwd_byte_if;
  logic                         valid;
  logic                         ready;
  logic [crcwd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
  modport mon    (input valid, input rx_byte, input ready);
endinterface

interface crcwd_word_if;
  logic                          valid;
  logic                          ready;
  logic [crcwd_pkg::WORD_W-1:0]  word_value;
  logic [crcwd_pkg::INDEX_W-1:0] word_index;
  logic                          status;
  logic                          last;

  modport source (output valid, output word_value, output word_index, output status,
                  output last, input ready);
  modport sink   (input valid, input word_value, input word_index, input status,
                  input last, output ready);
  modport mon    (input valid, input word_value, input word_index, input status,
                  input last, input ready);
endinterface

`default_nettype wire

// ===== rtl/core/crcwd_in_stage.sv =====
// Input register for received bytes; frees itself when the framer takes the byte.
// Depends on crcwd_pkg and crcwd_if.
`timescale 1ns / 1ps
`default_nettype none

module crcwd_in_stage (
  input  wire logic                   clk,
  input  wire logic                   rst,
  crcwd_byte_if.sink                  rx,
  input  wire logic                   take,
  output crcwd_pkg::byte_stage_t      stage
);

  logic                         s_valid;
  logic [crcwd_pkg::BYTE_W-1:0] s_data;

  assign rx.ready = !rst && (!s_valid || take);
  assign stage    = '{valid: s_valid, data: s_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s_valid <= 1'b1;
    end else if (take) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s_data <= rx.rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/crcwd_framer.sv =====
// Word framing, CRC-8 check, transaction counting and the result register.
// Depends on crcwd_pkg and crcwd_if.
`timescale 1ns / 1ps
`default_nettype none

module crcwd_framer #(
  parameter int MAX_WORDS = crcwd_pkg::MAX_WORDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [crcwd_pkg::WPR_W-1:0] cfg_wdata,
  input  wire crcwd_pkg::byte_stage_t      stage,
  output logic                             take,
  crcwd_word_if.source                     result
);

  localparam int CNT_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LIM_W  = $clog2(MAX_WORDS + 1);
  localparam int CMP_W  = ((LIM_W > crcwd_pkg::WPR_W) ? LIM_W : crcwd_pkg::WPR_W) + 1;
  localparam int IDX_W  = crcwd_pkg::INDEX_W;
  localparam int BYTE_W = crcwd_pkg::BYTE_W;

  logic [crcwd_pkg::WPR_W-1:0] words_per_read;
  crcwd_pkg::phase_t           phase;
  logic [CNT_W-1:0]            word_count;
  logic [BYTE_W-1:0]           high_byte;
  logic [BYTE_W-1:0]           low_byte;
  logic [BYTE_W-1:0]           crc_running;
  logic                        discarding;

  logic                        out_valid;
  logic [crcwd_pkg::WORD_W-1:0] out_word;
  logic [IDX_W-1:0]            out_index;
  logic                        out_status;
  logic                        out_last;

  logic [CMP_W-1:0]  wpr_ext;
  logic [CMP_W-1:0]  n_lim;
  logic              final_word;
  logic              bad;
  logic              emit;
  logic [BYTE_W-1:0] crc_next;

  assign take = stage.valid && (!out_valid || result.ready);

  // zero acts as one, oversize clamps to MAX_WORDS
  assign wpr_ext = CMP_W'(words_per_read);
  always_comb begin
    if (wpr_ext == '0) begin
      n_lim = CMP_W'(1);
    end else if (wpr_ext > CMP_W'(MAX_WORDS)) begin
      n_lim = CMP_W'(MAX_WORDS);
    end else begin
      n_lim = wpr_ext;
    end
  end

  assign final_word = (CMP_W'(word_count) + CMP_W'(1)) >= n_lim;
  assign bad        = crc_running != stage.data;
  assign crc_next   = crcwd_pkg::crc8_byte(
                        (phase == crcwd_pkg::PH_MSB) ? crcwd_pkg::CRC_INIT : crc_running,
                        stage.data);
  assign emit       = take && (phase == crcwd_pkg::PH_CRC) && !discarding;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_per_read <= crcwd_pkg::WPR_RESET;
      phase          <= crcwd_pkg::PH_MSB;
      word_count     <= '0;
      discarding     <= 1'b0;
    end else if (cfg_we) begin
      words_per_read <= cfg_wdata;
      phase          <= crcwd_pkg::PH_MSB;
      word_count     <= '0;
      discarding     <= 1'b0;
    end else if (take) begin
      unique case (phase)
        crcwd_pkg::PH_MSB: begin
          high_byte   <= stage.data;
          crc_running <= crc_next;
          phase       <= crcwd_pkg::PH_LSB;
        end
        crcwd_pkg::PH_LSB: begin
          low_byte    <= stage.data;
          crc_running <= crc_next;
          phase       <= crcwd_pkg::PH_CRC;
        end
        crcwd_pkg::PH_CRC: begin
          phase <= crcwd_pkg::PH_MSB;
          if (final_word) begin
            word_count <= '0;
            discarding <= 1'b0;
          end else begin
            word_count <= word_count + CNT_W'(1);
            if (!discarding && bad) begin
              discarding <= 1'b1;
            end
          end
        end
        default: begin
          phase <= crcwd_pkg::PH_MSB;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word   <= {high_byte, low_byte};
      out_index  <= IDX_W'(word_count);
      out_status <= bad;
      out_last   <= bad || final_word;
    end
  end

  assign result.valid      = out_valid;
  assign result.word_value = out_word;
  assign result.word_index = out_index;
  assign result.status     = out_status;
  assign result.last       = out_last;

endmodule

`default_nettype wire

// ===== rtl/core/crc_checked_word_deframer.sv =====
// Top level of the CRC-checked word deframer: input register and framer.
// Depends on crcwd_pkg, crcwd_if, crcwd_in_stage and crcwd_framer.
//
// Takes the bytes of a sensor read, one per transfer, in wire order MSB, LSB, CRC.
// Each third byte yields one result: the 16-bit word, its index in the transaction,
// a status (0 ok, 1 CRC-8 mismatch; poly 0x31, init 0xFF) and a last flag. After
// words_per_read words (0 acts as 1, values above MAX_WORDS clamp) the count wraps.
// A mismatch is flagged last and the rest of that transaction's bytes are dropped.
// A write to words_per_read restarts the transaction; write it only while idle.
// Rate: one byte per cycle while the result is not stalled. A byte is registered on entry
// and then processed by the framer, which loads the result register on the CRC byte;
// the result register lets a new byte enter while a word waits.
`timescale 1ns / 1ps
`default_nettype none

module crc_checked_word_deframer #(
  parameter int MAX_WORDS = crcwd_pkg::MAX_WORDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [crcwd_pkg::WPR_W-1:0] cfg_wdata,
  crcwd_byte_if.sink                       rx,
  crcwd_word_if.source                     result
);

  crcwd_pkg::byte_stage_t stage;
  logic                   take;

  crcwd_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .take  (take),
    .stage (stage)
  );

  crcwd_framer #(
    .MAX_WORDS (MAX_WORDS)
  ) u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stage     (stage),
    .take      (take),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== rtl/core/crcwd_checker.sv =====
// Port-level assertions for crc_checked_word_deframer, attached by bind.
// Depends on crcwd_pkg and the top level.
`timescale 1ns / 1ps
`default_nettype none

module crcwd_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          rx_valid,
  input wire logic                          rx_ready,
  input wire logic                          res_valid,
  input wire logic                          res_ready,
  input wire logic [crcwd_pkg::WORD_W-1:0]  word_value,
  input wire logic [crcwd_pkg::INDEX_W-1:0] word_index,
  input wire logic                          status,
  input wire logic                          last
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(word_value)
      && $stable(word_index) && $stable(last))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && status |-> last)
    else $error("mismatch result not marked last");

  // a fresh result comes from an earlier byte transfer through the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(rx_valid && rx_ready, 2))
    else $error("result without matching byte transfer");

endmodule

bind crc_checked_word_deframer crcwd_checker u_crcwd_checker (
  .clk        (clk),
  .rst        (rst),
  .rx_valid   (rx.valid),
  .rx_ready   (rx.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .word_value (result.word_value),
  .word_index (result.word_index),
  .status     (result.status),
  .last       (result.last)
);

`default_nettype wire
